/* rtl/cpim_pkg.sv */
// Shared constants and register codes for the constant-padding index map.
// No dependencies.
`timescale 1ns / 1ps
package cpim_pkg;

	localparam int DIM_BITS_DEF   = 16;
	localparam int INDEX_BITS_DEF = 32;
	localparam int EXT_W          = 16;
	localparam int BOX_W          = 64;
	localparam int CFG_DATA_W     = 64;
	localparam int WORD_W         = 32;

	typedef enum logic [2:0] {
		REG_OUT_N     = 3'd0,
		REG_OUT_C     = 3'd1,
		REG_OUT_H     = 3'd2,
		REG_OUT_W     = 3'd3,
		REG_BOX_BEGIN = 3'd4,
		REG_BOX_END   = 3'd5,
		REG_FILL      = 3'd6
	} cfg_reg_t;

endpackage

/* rtl/cpim_div_cell.sv */
// One restoring division step: one quotient bit per cell.
// Depends on cpim_pkg.
`timescale 1ns / 1ps
module cpim_div_cell
	import cpim_pkg::*;
#(
	parameter int DB = DIM_BITS_DEF,
	parameter int IB = INDEX_BITS_DEF,
	parameter int SW = 3 * DIM_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_in,
	input  logic [DB-1:0] rem_in,
	input  logic [IB-1:0] num_in,
	input  logic [SW-1:0] side_in,
	input  logic [DB-1:0] divisor,
	output logic          v_out,
	output logic [DB-1:0] rem_out,
	output logic [IB-1:0] num_out,
	output logic [SW-1:0] side_out
);

	logic [DB:0]   trial;
	logic [DB:0]   diff;
	logic          ge;
	logic          v_q;
	logic [DB-1:0] rem_q;
	logic [IB-1:0] num_q;
	logic [SW-1:0] side_q;

	assign trial = {rem_in, num_in[IB-1]};
	assign diff  = trial - {1'b0, divisor};
	assign ge    = trial >= {1'b0, divisor};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q  <= ge ? diff[DB-1:0] : trial[DB-1:0];
			num_q  <= {num_in[IB-2:0], ge};
			side_q <= side_in;
		end
	end

	assign v_out    = v_q;
	assign rem_out  = rem_q;
	assign num_out  = num_q;
	assign side_out = side_q;

endmodule

/* rtl/cpim_mac_cell.sv */
// One dimension of the box test and source index accumulation.
// Depends on cpim_pkg.
`timescale 1ns / 1ps
module cpim_mac_cell
	import cpim_pkg::*;
#(
	parameter int DB = DIM_BITS_DEF,
	parameter int IB = INDEX_BITS_DEF,
	parameter int SW = 4 * DIM_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          v_in,
	input  logic          ok_in,
	input  logic          inb_in,
	input  logic [IB-1:0] acc_in,
	input  logic [SW-1:0] side_in,
	input  logic [DB-1:0] crd,
	input  logic [DB-1:0] lo,
	input  logic [DB-1:0] hi,
	output logic          v_out,
	output logic          ok_out,
	output logic          inb_out,
	output logic [IB-1:0] acc_out,
	output logic [SW-1:0] side_out
);

	logic [DB-1:0]    span;
	logic [DB-1:0]    off;
	logic [IB+DB-1:0] prod;
	logic [IB+DB-1:0] sum;
	logic             hit;
	logic             v_q;
	logic             ok_q;
	logic             inb_q;
	logic [IB-1:0]    acc_q;
	logic [SW-1:0]    side_q;

	assign hit  = (crd >= lo) && (crd < hi);
	assign span = hi - lo;
	assign off  = crd - lo;
	assign prod = {{DB{1'b0}}, acc_in} * {{IB{1'b0}}, span};
	assign sum  = prod + {{IB{1'b0}}, off};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ok_q   <= ok_in;
			inb_q  <= inb_in & hit;
			acc_q  <= sum[IB-1:0];
			side_q <= side_in;
		end
	end

	assign v_out    = v_q;
	assign ok_out   = ok_q;
	assign inb_out  = inb_q;
	assign acc_out  = acc_q;
	assign side_out = side_q;

endmodule

/* rtl/constant_pad_index_map_top.sv */
// Top level of the constant-padding index map: registers, divider chain, box chain.
// Depends on cpim_pkg, cpim_div_cell and cpim_mac_cell.
//
//   channel | signals                                     | direction
//   input   | in_valid, in_ready, out_index               | in
//   result  | out_valid, out_ready, is_fill, source_index,| out
//           | index_valid                                 |
//   config  | cfg_valid, cfg_ready, cfg_index, cfg_data   | in
//
// One word per cycle while the chain is not held; one cell per quotient bit for the w,
// h and c divisions, then one cell per dimension for the box test.
// The whole chain advances together; it holds while the result stage is full
// and out_ready is low. Reset clears the valid bits and loads the register defaults.
`timescale 1ns / 1ps
module constant_pad_index_map_top
	import cpim_pkg::*;
#(
	parameter int DIM_BITS   = DIM_BITS_DEF,
	parameter int INDEX_BITS = INDEX_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [WORD_W-1:0]     out_index,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  is_fill,
	output logic [WORD_W-1:0]     source_index,
	output logic                  index_valid,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int DB   = DIM_BITS;
	localparam int IB   = INDEX_BITS;
	localparam int NDIV = 3 * IB;
	localparam int DSW  = 3 * DB;
	localparam int MSW  = 4 * DB;

	logic [EXT_W-1:0] ext_n_q, ext_c_q, ext_h_q, ext_w_q;
	logic [BOX_W-1:0] box_begin_q, box_end_q;
	logic             en;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ext_n_q     <= EXT_W'(1);
			ext_c_q     <= EXT_W'(1);
			ext_h_q     <= EXT_W'(1);
			ext_w_q     <= EXT_W'(1);
			box_begin_q <= '0;
			box_end_q   <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_OUT_N:     ext_n_q     <= cfg_data[EXT_W-1:0];
				REG_OUT_C:     ext_c_q     <= cfg_data[EXT_W-1:0];
				REG_OUT_H:     ext_h_q     <= cfg_data[EXT_W-1:0];
				REG_OUT_W:     ext_w_q     <= cfg_data[EXT_W-1:0];
				REG_BOX_BEGIN: box_begin_q <= cfg_data;
				REG_BOX_END:   box_end_q   <= cfg_data;
				// fill pattern belongs to the data path; no index depends on it
				default: ;
			endcase
		end
	end

	logic [DB-1:0] dvs [0:2];
	assign dvs[0] = ext_w_q[DB-1:0];
	assign dvs[1] = ext_h_q[DB-1:0];
	assign dvs[2] = ext_c_q[DB-1:0];

	logic [IB+WORD_W-1:0] idx_wide;
	assign idx_wide = {{IB{1'b0}}, out_index};

	logic          dv   [0:NDIV];
	logic [DB-1:0] drem [0:NDIV];
	logic [IB-1:0] dnum [0:NDIV];
	logic [DSW-1:0] dside [0:NDIV];

	assign dv[0]    = in_valid;
	assign drem[0]  = '0;
	assign dnum[0]  = idx_wide[IB-1:0];
	assign dside[0] = '0;

	generate
		for (genvar i = 0; i < NDIV; i++) begin : g_div
			localparam int D = i / IB;
			localparam int B = i % IB;
			logic [DB-1:0]  rem_in;
			logic [DSW-1:0] side_in;
			if (B == 0 && D > 0) begin : g_first
				always_comb begin
					side_in = dside[i];
					side_in[(D-1)*DB +: DB] = drem[i];
				end
				assign rem_in = '0;
			end else begin : g_next
				assign side_in = dside[i];
				assign rem_in  = drem[i];
			end
			cpim_div_cell #(.DB(DB), .IB(IB), .SW(DSW)) u_cell (
				.clk(clk), .arst_n(arst_n), .en(en),
				.v_in(dv[i]), .rem_in(rem_in), .num_in(dnum[i]), .side_in(side_in),
				.divisor(dvs[D]),
				.v_out(dv[i+1]), .rem_out(drem[i+1]), .num_out(dnum[i+1]),
				.side_out(dside[i+1])
			);
		end
	endgenerate

	logic [IB+DB-1:0] crd_n_wide;
	logic [IB+DB-1:0] ext_n_wide;
	logic             ok0;
	assign crd_n_wide = {{DB{1'b0}}, dnum[NDIV]};
	assign ext_n_wide = {{IB{1'b0}}, ext_n_q[DB-1:0]};
	assign ok0 = (ext_n_q[DB-1:0] != '0) && (ext_c_q[DB-1:0] != '0) &&
		(ext_h_q[DB-1:0] != '0) && (ext_w_q[DB-1:0] != '0) &&
		(crd_n_wide < ext_n_wide);

	logic           mv   [0:4];
	logic           mok  [0:4];
	logic           minb [0:4];
	logic [IB-1:0]  macc [0:4];
	logic [MSW-1:0] mside [0:4];

	assign mv[0]    = dv[NDIV];
	assign mok[0]   = ok0;
	assign minb[0]  = 1'b1;
	assign macc[0]  = '0;
	assign mside[0] = {crd_n_wide[DB-1:0], drem[NDIV], dside[NDIV][2*DB-1:0]};

	generate
		for (genvar k = 0; k < 4; k++) begin : g_mac
			localparam int S = 3 - k;
			cpim_mac_cell #(.DB(DB), .IB(IB), .SW(MSW)) u_cell (
				.clk(clk), .arst_n(arst_n), .en(en),
				.v_in(mv[k]), .ok_in(mok[k]), .inb_in(minb[k]), .acc_in(macc[k]),
				.side_in(mside[k]),
				.crd(mside[k][S*DB +: DB]),
				.lo(box_begin_q[S*EXT_W +: DB]),
				.hi(box_end_q[S*EXT_W +: DB]),
				.v_out(mv[k+1]), .ok_out(mok[k+1]), .inb_out(minb[k+1]),
				.acc_out(macc[k+1]), .side_out(mside[k+1])
			);
		end
	endgenerate

	logic [IB+WORD_W-1:0] src_wide;
	assign src_wide = {{WORD_W{1'b0}}, macc[4]};

	assign en           = !mv[4] || out_ready;
	assign in_ready     = en;
	assign out_valid    = mv[4];
	assign index_valid  = mok[4];
	assign is_fill      = mok[4] && !minb[4];
	assign source_index = (mok[4] && minb[4]) ? src_wide[WORD_W-1:0] : '0;

endmodule

/* dv/testbench.sv */
// Self-checking testbench for constant_pad_index_map_top: random and directed indices
// against a behavioural model of the NCHW padding address map. Depends on cpim_pkg.
`timescale 1ns / 1ps
module testbench;
	import cpim_pkg::*;

	typedef struct packed {
		logic        fill;
		logic [31:0] src;
		logic        ok;
	} pad_word_t;

	class pad_scoreboard;
		logic [15:0] ext [4];
		logic [63:0] bbeg, bend;
		pad_word_t   pending[$];
		int          errors;
		int          checked;
		int          fills;
		int          invalids;

		function void clear();
			for (int k = 0; k < 4; k++) ext[k] = 16'd1;
			bbeg = '0;
			bend = '0;
			pending.delete();
			errors = 0;
			checked = 0;
			fills = 0;
			invalids = 0;
		endfunction

		function void write_reg(cfg_reg_t r, logic [63:0] d);
			case (r)
				REG_OUT_N: ext[0] = d[15:0];
				REG_OUT_C: ext[1] = d[15:0];
				REG_OUT_H: ext[2] = d[15:0];
				REG_OUT_W: ext[3] = d[15:0];
				REG_BOX_BEGIN: bbeg = d;
				REG_BOX_END: bend = d;
				default: ;
			endcase
		endfunction

		function void note_index(logic [31:0] idx);
			pad_word_t   w;
			logic [63:0] total, rest, src, b, e;
			logic [63:0] crd [4];
			bit          in_box;
			w = '0;
			total = 64'(ext[0]) * ext[1] * ext[2] * ext[3];
			if (total != 0 && 64'(idx) < total) begin
				rest = 64'(idx);
				for (int k = 3; k > 0; k--) begin
					crd[k] = rest % ext[k];
					rest = rest / ext[k];
				end
				crd[0] = rest;
				src = 0;
				in_box = 1;
				for (int k = 0; k < 4; k++) begin
					b = 64'(bbeg[(3 - k) * 16 +: 16]);
					e = 64'(bend[(3 - k) * 16 +: 16]);
					if (crd[k] < b || crd[k] >= e) begin
						in_box = 0;
						break;
					end
					src = src * (e - b) + (crd[k] - b);
				end
				w.ok = 1'b1;
				w.fill = !in_box;
				w.src = in_box ? src[31:0] : 32'd0;
			end
			pending.push_back(w);
		endfunction

		function void check_word(pad_word_t got);
			pad_word_t exp;
			if (pending.size() == 0) begin
				$display("%0t: unexpected word fill=%0b src=%0h valid=%0b", $time,
					got.fill, got.src, got.ok);
				errors++;
				return;
			end
			exp = pending.pop_front();
			checked++;
			if (!exp.ok) invalids++;
			else if (exp.fill) fills++;
			if (got.fill !== exp.fill) begin
				$display("%0t: is_fill expected %0b actual %0b", $time, exp.fill, got.fill);
				errors++;
			end
			if (got.src !== exp.src) begin
				$display("%0t: source_index expected %0h actual %0h", $time, exp.src,
					got.src);
				errors++;
			end
			if (got.ok !== exp.ok) begin
				$display("%0t: index_valid expected %0b actual %0b", $time, exp.ok,
					got.ok);
				errors++;
			end
		endfunction
	endclass

	localparam int LATENCY = 3 * INDEX_BITS_DEF + 4;
	localparam int STALL_LIMIT = 20000;

	logic        clk;
	logic        arst_n;
	logic        in_valid, in_ready;
	logic [31:0] out_index;
	logic        out_valid, out_ready;
	logic        is_fill;
	logic [31:0] source_index;
	logic        index_valid;
	logic        cfg_valid, cfg_ready;
	logic [2:0]  cfg_index;
	logic [63:0] cfg_data;

	pad_scoreboard board;
	int            idle_cycles;
	int            sent;
	int            sink_wait;
	int            sink_draw;

	constant_pad_index_map_top dut (.*);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	task automatic set_reg(cfg_reg_t r, logic [63:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(r, d);
	endtask

	task automatic send_index(logic [31:0] idx);
		int gap;
		gap = $urandom_range(0, 16);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		out_index <= idx;
		do @(posedge clk); while (!in_ready);
		board.note_index(idx);
		sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic load_shape(logic [15:0] n, logic [15:0] c, logic [15:0] h,
		logic [15:0] w, logic [63:0] b, logic [63:0] e);
		drain();
		set_reg(REG_OUT_N, 64'(n));
		set_reg(REG_OUT_C, 64'(c));
		set_reg(REG_OUT_H, 64'(h));
		set_reg(REG_OUT_W, 64'(w));
		set_reg(REG_BOX_BEGIN, b);
		set_reg(REG_BOX_END, e);
		set_reg(REG_FILL, {32'd0, $urandom()});
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [63:0] pack4(int a, int b, int c, int d);
		return {16'(a), 16'(b), 16'(c), 16'(d)};
	endfunction

	function automatic logic [31:0] total_of();
		return 32'(64'(board.ext[0]) * board.ext[1] * board.ext[2] * board.ext[3]);
	endfunction

	// Sink side: wait a drawn number of cycles per word, check on every accepted word.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			sink_wait <= 0;
		end else if (out_valid && out_ready) begin
			board.check_word('{is_fill, source_index, index_valid});
			sink_draw = $urandom_range(0, 16);
			out_ready <= (sink_draw == 0);
			sink_wait <= sink_draw;
		end else if (!out_ready) begin
			if (sink_wait <= 1)
				out_ready <= 1'b1;
			sink_wait <= sink_wait - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idle_cycles <= 0;
		end else if ((in_valid && in_ready) || (out_valid && out_ready) ||
			(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	initial begin
		logic [15:0] n, c, h, w;
		int          bn, bc, bh, bw;
		logic [31:0] tot;
		board = new();
		board.clear();
		sent = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_index = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_OUT_N;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset shape: single element, empty box.
		send_index(32'd0);
		send_index(32'd1);
		send_index(32'hFFFF_FFFF);

		// Small shape, box inside.
		load_shape(2, 3, 4, 5, pack4(0, 1, 1, 1), pack4(2, 3, 3, 4));
		for (int i = 0; i < 8; i++) send_index(32'($urandom_range(0, 125)));
		send_index(32'd119);
		send_index(32'd120);

		// Zero extent.
		load_shape(4, 0, 4, 4, pack4(0, 0, 0, 0), pack4(4, 4, 4, 4));
		send_index(32'd0);
		send_index(32'd5);

		// Box beyond output, empty box in one dimension.
		load_shape(3, 3, 3, 3, pack4(0, 0, 2, 0), pack4(9, 9, 2, 9));
		send_index(32'd0);
		send_index(32'd26);
		load_shape(3, 3, 3, 3, 64'd0, {64{1'b1}});
		send_index(32'd26);
		send_index(32'd13);

		// Full extents: element count far past the index range.
		load_shape(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 64'd0, {64{1'b1}});
		send_index(32'hFFFF_FFFF);
		send_index(32'h8000_0000);
		send_index(32'h0001_2345);

		// Random phases.
		for (int p = 0; p < 35; p++) begin
			if (p % 7 == 6) begin
				n = 16'($urandom_range(1, 65535));
				c = 16'($urandom_range(1, 65535));
				h = 16'($urandom_range(0, 65535));
				w = 16'($urandom_range(1, 65535));
			end else begin
				n = 16'($urandom_range(1, 6));
				c = 16'($urandom_range(1, 6));
				h = 16'($urandom_range(1, 12));
				w = 16'($urandom_range(1, 12));
			end
			bn = $urandom_range(0, n); bc = $urandom_range(0, c);
			bh = $urandom_range(0, h); bw = $urandom_range(0, w);
			if (p % 5 == 4)
				load_shape(n, c, h, w, {$urandom(), $urandom()}, {$urandom(), $urandom()});
			else
				load_shape(n, c, h, w, pack4(bn / 2, bc / 2, bh / 2, bw / 2),
					pack4(bn + $urandom_range(0, 2), bc + $urandom_range(0, 2),
						bh + $urandom_range(0, 2), bw + $urandom_range(0, 2)));
			tot = total_of();
			for (int i = 0; i < 50; i++) begin
				if ($urandom_range(0, 9) == 0 || tot == 0)
					send_index($urandom());
				else
					send_index(32'($urandom_range(0, tot - 1)));
				// Hold the input until the pipeline has emptied.
				if (i == 25 && p % 4 == 0) begin
					in_valid <= 1'b0;
					while (board.pending.size() != 0) @(posedge clk);
				end
			end
		end

		drain();
		$display("Sent %0d indices: %0d checked, %0d padded, %0d out of range.",
			sent, board.checked, board.fills, board.invalids);
		$display("Shapes covered reset, zero extent, clipped and empty boxes, full extents.");
		if (board.errors == 0 && board.pending.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
